>>> rtl/rgb_conv3x3_edge_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGB 3x3 edge filter
// Shared property forms used by the checker of the filter core.
// ----------------------------------------------------------------------------
`ifndef RGB_CONV3X3_EDGE_FILTER_CORE_MACROS_SVH
`define RGB_CONV3X3_EDGE_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rgbf_pkg.sv
// ----------------------------------------------------------------------------
// RGB 3x3 edge filter package
// Sizes, codes, types and the kernel arithmetic shared by the filter files.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  // Rows run up to two past the frame while the tail is drained.
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
  localparam int KSEL_W     = 2;
  localparam int FW_FIELD_W = 12;
  localparam int FH_FIELD_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int RESET_WIDTH  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int RESET_HEIGHT = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  // Holds the queue fill plus the two words still in the pipeline.
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 3);

  localparam int KERNEL_COUNT = 3;
  localparam int TAP_COUNT    = 9;
  localparam int TAP_W        = 5;
  localparam int SUM_W        = 12;
  localparam int SAT_MAX      = 255;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_SELECT = 2'd0,
    REG_FRAME_WIDTH   = 2'd1,
    REG_FRAME_HEIGHT  = 2'd2
  } reg_idx_t;

  typedef enum logic [KSEL_W-1:0] {
    KERNEL_LAP8 = 2'd0,
    KERNEL_LAP4 = 2'd1,
    KERNEL_DIAG = 2'd2
  } kernel_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // One column of the 3x3 window, oldest row on top.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  // Word in the line-store stage.
  typedef struct packed {
    pix_t             pix;
    logic [COL_W-1:0] col;
    logic             have;
    logic             last;
    logic             left_zero;
    logic             right_en;
    logic             up1;
    logic             up2;
  } s1_t;

  typedef struct packed {
    pix_t pix;
    logic frame_end;
  } res_t;

  // Taps in raster order: top-left first, bottom-right last.
  localparam logic signed [TAP_W-1:0] TAPS [KERNEL_COUNT][TAP_COUNT] = '{
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{ 5'sd0,  5'sd1,  5'sd0,  5'sd1, -5'sd4,  5'sd1,  5'sd0,  5'sd1,  5'sd0},
    '{-5'sd1,  5'sd0,  5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd0, -5'sd1}
  };

  // Convolves one channel of the window and saturates to 0..255.
  // An unused kernel code falls back to the 8-neighbour Laplacian.
  function automatic logic [CH_W-1:0] conv_sat(
    input logic [KSEL_W-1:0]                 ksel,
    input logic [TAP_COUNT-1:0][CH_W-1:0]    px
  );
    logic signed [SUM_W-1:0] acc [KERNEL_COUNT];
    logic signed [SUM_W-1:0] sel;
    logic [CH_W-1:0]         res;
    for (int k = 0; k < KERNEL_COUNT; k++) begin
      acc[k] = '0;
      for (int i = 0; i < TAP_COUNT; i++) begin
        acc[k] = acc[k] + SUM_W'(TAPS[k][i]) * $signed(SUM_W'(px[i]));
      end
    end
    unique case (ksel)
      KERNEL_LAP4: sel = acc[1];
      KERNEL_DIAG: sel = acc[2];
      default:     sel = acc[0];
    endcase
    if (sel < 0) begin
      res = '0;
    end else if (sel > SUM_W'(SAT_MAX)) begin
      res = CH_W'(SAT_MAX);
    end else begin
      res = sel[CH_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rgbf_channels.sv
// ----------------------------------------------------------------------------
// RGB 3x3 edge filter channels
// Valid/ready interfaces for the pixel input, the result output and the
// register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbf_pix_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [rgbf_pkg::CH_W-1:0] red_in;
  logic [rgbf_pkg::CH_W-1:0] green_in;
  logic [rgbf_pkg::CH_W-1:0] blue_in;
  modport source (output valid, kind, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface rgbf_res_if;
  logic                      valid;
  logic                      ready;
  logic [rgbf_pkg::CH_W-1:0] red_out;
  logic [rgbf_pkg::CH_W-1:0] green_out;
  logic [rgbf_pkg::CH_W-1:0] blue_out;
  logic                      frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface rgbf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rgbf_pkg::CFG_IDX_W-1:0]  index;
  logic [rgbf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/rgb_conv3x3_edge_filter_core.sv
// ----------------------------------------------------------------------------
// RGB 3x3 edge filter core
// Streams raster-order RGB pixels through a per-channel 3x3 edge kernel.
// ----------------------------------------------------------------------------
// Usage: pixel words enter on in_pix (kind 0) in raster order, frame_width
// pixels per row and frame_height rows. Each output word on out_pix is one
// row and one column behind its input, so after the last pixel the source
// sends frame_width + 1 drain words (kind 1) to flush the tail; the output
// word of the frame's last pixel carries frame_end. Drain words sent too
// early and pixels sent during the drain are dropped without a result.
// Registers must be written on cfg_wr (always ready) only while the core is
// idle; the core does not enforce it. Index 0 picks the kernel, 1 and 2 set
// the frame size and restart the frame. Throughput is one word per cycle
// while in_pix.ready is high; the line store is a single-port-write memory
// read once and written once per word. Results pass the line-store and
// kernel stage registers and a four-entry result queue that parts the two
// sides: in_pix.ready depends on registers only and stays high while the
// queue and the two pipeline stages hold fewer than four words, so a stalled
// receiver back-pressures the input at four words. Synchronous reset clears
// position, registers and queue; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_conv3x3_edge_filter_core (
  input wire         clk,
  input wire         rst_n,
  rgbf_pix_if.sink   in_pix,
  rgbf_res_if.source out_pix,
  rgbf_cfg_if.sink   cfg_wr
);

  // Configuration and stream position.
  logic [rgbf_pkg::KSEL_W-1:0] ksel_r;
  logic [rgbf_pkg::COL_W-1:0]  w_last_r;
  logic [rgbf_pkg::ROW_W-1:0]  h_r;
  logic [rgbf_pkg::COL_W-1:0]  col_r;
  logic [rgbf_pkg::ROW_W-1:0]  row_r;
  logic [rgbf_pkg::COL_W-1:0]  col_nxt;
  logic [rgbf_pkg::ROW_W-1:0]  row_nxt;

  logic [rgbf_pkg::FW_FIELD_W-1:0] fw_field;
  logic [rgbf_pkg::FH_FIELD_W-1:0] fh_field;
  logic [rgbf_pkg::COL_W-1:0]      w_last_cfg;
  logic [rgbf_pkg::ROW_W-1:0]      h_cfg;
  logic                            cfg_acc;

  // Input stage.
  logic         in_acc;
  logic         row_in_frame;
  logic         item_live;
  logic         col_zero;
  logic         row_end;
  logic         frame_done;
  rgbf_pkg::s1_t s1_nxt;

  // Line-store stage.
  logic [2*rgbf_pkg::PIX_W-1:0] line_mem [rgbf_pkg::MAX_WIDTH];
  logic [2*rgbf_pkg::PIX_W-1:0] mem_rdata_r;
  logic [2*rgbf_pkg::PIX_W-1:0] rd_word;
  logic [2*rgbf_pkg::PIX_W-1:0] mem_wdata;
  logic                         mem_we;
  logic                         fwd_vld_r;
  logic [rgbf_pkg::COL_W-1:0]   fwd_addr_r;
  logic [2*rgbf_pkg::PIX_W-1:0] fwd_data_r;
  logic                         s1_vld_r;
  rgbf_pkg::s1_t                s1_r;
  rgbf_pkg::pix_t               prev1;
  rgbf_pkg::pix_t               prev2;
  rgbf_pkg::column_t            col_new;
  rgbf_pkg::column_t            win_l_r;
  rgbf_pkg::column_t            win_m_r;

  // Kernel stage.
  logic                         s2_vld_r;
  logic                         s2_last_r;
  rgbf_pkg::column_t            s2_cols_r [3];
  logic [rgbf_pkg::TAP_COUNT-1:0][rgbf_pkg::CH_W-1:0] red_px;
  logic [rgbf_pkg::TAP_COUNT-1:0][rgbf_pkg::CH_W-1:0] green_px;
  logic [rgbf_pkg::TAP_COUNT-1:0][rgbf_pkg::CH_W-1:0] blue_px;
  rgbf_pkg::res_t               res_word;

  // Result queue.
  rgbf_pkg::res_t                  fifo_mem [rgbf_pkg::FIFO_DEPTH];
  logic [rgbf_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [rgbf_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [rgbf_pkg::FIFO_CNT_W-1:0] cnt_r;
  logic [rgbf_pkg::FIFO_CNT_W-1:0] credit;
  logic                            push;
  logic                            pop;

  // --------------------------------------------------------------------------
  // Register writes. Out-of-range sizes are clamped when they are written,
  // and the width is kept as its last column index.
  // --------------------------------------------------------------------------
  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid;
  assign fw_field     = cfg_wr.data[rgbf_pkg::FW_FIELD_W-1:0];
  assign fh_field     = cfg_wr.data[rgbf_pkg::FH_FIELD_W-1:0];

  always_comb begin
    if (fw_field == '0) begin
      w_last_cfg = '0;
    end else if (int'(fw_field) > rgbf_pkg::MAX_WIDTH) begin
      w_last_cfg = rgbf_pkg::COL_W'(rgbf_pkg::MAX_WIDTH - 1);
    end else begin
      w_last_cfg = rgbf_pkg::COL_W'(fw_field - 1'b1);
    end
    if (fh_field == '0) begin
      h_cfg = rgbf_pkg::ROW_W'(1);
    end else if (int'(fh_field) > rgbf_pkg::MAX_HEIGHT) begin
      h_cfg = rgbf_pkg::ROW_W'(rgbf_pkg::MAX_HEIGHT);
    end else begin
      h_cfg = rgbf_pkg::ROW_W'(fh_field);
    end
  end

  // --------------------------------------------------------------------------
  // Input stage. A pixel word counts only while the frame is still coming in,
  // a drain word only once it is complete; anything else is dropped here.
  // The last output of the frame always falls on column zero two rows below
  // the last frame row.
  // --------------------------------------------------------------------------
  assign in_acc       = in_pix.valid && in_pix.ready;
  assign row_in_frame = row_r < h_r;
  assign item_live    = in_acc && ((in_pix.kind == rgbf_pkg::KIND_PIXEL) ?
                                   row_in_frame : !row_in_frame);
  assign col_zero     = col_r == '0;
  assign row_end      = col_r == w_last_r;
  assign frame_done   = col_zero && (row_r == rgbf_pkg::ROW_W'(h_r + 1'b1));

  always_comb begin
    if (frame_done) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = rgbf_pkg::ROW_W'(row_r + 1'b1);
    end else begin
      col_nxt = rgbf_pkg::COL_W'(col_r + 1'b1);
      row_nxt = row_r;
    end
  end

  always_comb begin
    s1_nxt.pix       = (in_pix.kind == rgbf_pkg::KIND_PIXEL) ?
                       {in_pix.red_in, in_pix.green_in, in_pix.blue_in} : '0;
    s1_nxt.col       = col_r;
    s1_nxt.have      = col_zero ? (row_r > rgbf_pkg::ROW_W'(1)) : (row_r != '0);
    s1_nxt.last      = frame_done;
    // The output column's left neighbor lies outside the frame.
    s1_nxt.left_zero = (col_r == rgbf_pkg::COL_W'(1)) || (col_zero && w_last_r == '0);
    // At column zero the output is the previous row's last pixel, whose right
    // neighbor is outside the frame.
    s1_nxt.right_en  = !col_zero;
    s1_nxt.up1       = row_r != '0;
    s1_nxt.up2       = row_r > rgbf_pkg::ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksel_r   <= rgbf_pkg::KERNEL_LAP8;
      w_last_r <= rgbf_pkg::COL_W'(rgbf_pkg::RESET_WIDTH - 1);
      h_r      <= rgbf_pkg::ROW_W'(rgbf_pkg::RESET_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_wr.index)
        rgbf_pkg::REG_KERNEL_SELECT: begin
          ksel_r <= cfg_wr.data[rgbf_pkg::KSEL_W-1:0];
        end
        rgbf_pkg::REG_FRAME_WIDTH: begin
          w_last_r <= w_last_cfg;
          col_r    <= '0;
          row_r    <= '0;
        end
        rgbf_pkg::REG_FRAME_HEIGHT: begin
          h_r   <= h_cfg;
          col_r <= '0;
          row_r <= '0;
        end
        default: begin
        end
      endcase
    end else if (item_live) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= item_live;
    end
  end

  always_ff @(posedge clk) begin
    if (item_live) begin
      s1_r <= s1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: one entry per column holds the two rows above the current
  // one. Each word reads its column in the input stage and writes it back
  // in the next cycle, shifted down by one row. When a frame is one pixel wide
  // the next word reads the entry in the very cycle it is written, so the last
  // write is forwarded.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_r.col] <= mem_wdata;
    end
    if (item_live) begin
      mem_rdata_r <= line_mem[col_r];
    end
  end

  assign rd_word = (fwd_vld_r && fwd_addr_r == s1_r.col) ? fwd_data_r : mem_rdata_r;
  assign prev1   = rd_word[2*rgbf_pkg::PIX_W-1:rgbf_pkg::PIX_W];
  assign prev2   = rd_word[rgbf_pkg::PIX_W-1:0];

  assign mem_we    = s1_vld_r;
  assign mem_wdata = {s1_r.pix, prev1};

  // Rows above the top of the frame read as zero, whatever the store holds.
  always_comb begin
    col_new.top = s1_r.up2 ? prev2 : '0;
    col_new.mid = s1_r.up1 ? prev1 : '0;
    col_new.bot = s1_r.pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_r.col;
    fwd_data_r <= mem_wdata;
  end

  // The window keeps the two previous columns; with the new column they form
  // the 3x3 neighborhood of the output pixel one column back.
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      win_l_r      <= win_m_r;
      win_m_r      <= col_new;
      s2_cols_r[0] <= s1_r.left_zero ? '0 : win_l_r;
      s2_cols_r[1] <= win_m_r;
      s2_cols_r[2] <= s1_r.right_en ? col_new : '0;
      s2_last_r    <= s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && s1_r.have;
    end
  end

  // --------------------------------------------------------------------------
  // Kernel stage: the three channels are filtered side by side.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      red_px[c]     = s2_cols_r[c].top.red;
      red_px[3+c]   = s2_cols_r[c].mid.red;
      red_px[6+c]   = s2_cols_r[c].bot.red;
      green_px[c]   = s2_cols_r[c].top.green;
      green_px[3+c] = s2_cols_r[c].mid.green;
      green_px[6+c] = s2_cols_r[c].bot.green;
      blue_px[c]    = s2_cols_r[c].top.blue;
      blue_px[3+c]  = s2_cols_r[c].mid.blue;
      blue_px[6+c]  = s2_cols_r[c].bot.blue;
    end
    res_word.pix.red   = rgbf_pkg::conv_sat(ksel_r, red_px);
    res_word.pix.green = rgbf_pkg::conv_sat(ksel_r, green_px);
    res_word.pix.blue  = rgbf_pkg::conv_sat(ksel_r, blue_px);
    res_word.frame_end = s2_last_r;
  end

  // --------------------------------------------------------------------------
  // Result queue. The input is held off once the queue together with the
  // words still in the pipeline could fill it.
  // --------------------------------------------------------------------------
  assign push   = s2_vld_r;
  assign pop    = out_pix.valid && out_pix.ready;
  assign credit = rgbf_pkg::FIFO_CNT_W'(cnt_r + rgbf_pkg::FIFO_CNT_W'(s1_vld_r)
                                        + rgbf_pkg::FIFO_CNT_W'(s2_vld_r));

  assign in_pix.ready = credit < rgbf_pkg::FIFO_CNT_W'(rgbf_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= rgbf_pkg::FIFO_PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= rgbf_pkg::FIFO_PTR_W'(rd_ptr_r + 1'b1);
      end
      cnt_r <= rgbf_pkg::FIFO_CNT_W'(cnt_r + rgbf_pkg::FIFO_CNT_W'(push)
                                     - rgbf_pkg::FIFO_CNT_W'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= res_word;
    end
  end

  assign out_pix.valid     = cnt_r != '0;
  assign out_pix.red_out   = fifo_mem[rd_ptr_r].pix.red;
  assign out_pix.green_out = fifo_mem[rd_ptr_r].pix.green;
  assign out_pix.blue_out  = fifo_mem[rd_ptr_r].pix.blue;
  assign out_pix.frame_end = fifo_mem[rd_ptr_r].frame_end;

endmodule

`default_nettype wire

>>> rtl/rgbf_checker.sv
// ----------------------------------------------------------------------------
// RGB 3x3 edge filter port checker
// Watches the core's pixel input and result output handshakes and its pipeline timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_conv3x3_edge_filter_core_macros.svh"

module rgbf_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready
);

  // A result word waits until it is taken.
  `RGBF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  // A result queue that runs empty refills only from a word taken at the input.
  `RGBF_ASSERT_SAME(a_out_latency, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 3), "result word without matching input")

  // The input is held off only while results are waiting.
  `RGBF_ASSERT_SAME(a_backpressure, clk, rst_n, !in_ready, out_valid, "input stalled with no result pending")

endmodule

bind rgb_conv3x3_edge_filter_core rgbf_checker u_rgbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready)
);

`default_nettype wire
